/* src/sgi_pkg.sv */
// ----------------------------------------------------------------------------
// sgi_pkg
// Types, constants and the divider step shared by the segment intersection
// pipeline.
// ----------------------------------------------------------------------------
package sgi_pkg;

   localparam int CoordW  = 24;          // Q15.8 coordinate
   localparam int DiffW   = CoordW + 1;  // difference of two coordinates
   localparam int ProdW   = 2 * DiffW;   // product of two differences
   localparam int CrossW  = ProdW + 1;   // difference of two products
   localparam int MagW    = CrossW - 1;  // magnitude of a normalized cross term
   localparam int RemW    = MagW + 1;    // remainder, holds up to twice den
   localparam int QuoW    = DiffW + 1;   // quotient, below 2^25
   localparam int EpsW    = 21;
   localparam int NumCells = DiffW;      // one cell per multiplier bit

   localparam logic [EpsW-1:0] EpsReset = 21'd66;

   typedef enum logic [1:0] {
      ST_HIT      = 2'd0,
      ST_PARALLEL = 2'd1,
      ST_MISS     = 2'd2
   } status_type;

   // partial state of one coordinate's scaled division
   typedef struct packed {
      logic [RemW-1:0] rem;
      logic [QuoW-1:0] quo;
   } lane_type;

   // beat handed from cell to cell
   typedef struct packed {
      status_type               status;
      logic [MagW-1:0]          den;
      logic [MagW-1:0]          tn;
      logic [DiffW-1:0]         mag_x;
      logic [DiffW-1:0]         mag_y;
      logic                     neg_x;
      logic                     neg_y;
      logic signed [CoordW-1:0] ax;
      logic signed [CoordW-1:0] ay;
      lane_type                 lx;
      lane_type                 ly;
   } cell_type;

   // one multiplier bit of (tn * mag) / den: double, reduce, add tn, reduce
   function automatic lane_type lane_step(lane_type l, logic [MagW-1:0] den,
                                          logic [MagW-1:0] tn, logic bit_in);
      logic [RemW-1:0] d;
      logic [RemW-1:0] r2;
      logic [RemW-1:0] r3;
      logic [QuoW-1:0] q2;
      lane_type        o;
      d  = {1'b0, den};
      r2 = {l.rem[RemW-2:0], 1'b0};
      q2 = {l.quo[QuoW-2:0], 1'b0};
      if (r2 >= d) begin
         r2 = r2 - d;
         q2 = q2 + 1'b1;
      end
      r3 = r2;
      if (bit_in) begin
         r3 = r2 + {1'b0, tn};
         if (r3 >= d) begin
            r3 = r3 - d;
            q2 = q2 + 1'b1;
         end
      end
      o.rem = r3;
      o.quo = q2;
      return o;
   endfunction

endpackage

/* src/sgi_ifs.sv */
// ----------------------------------------------------------------------------
// sgi channel interfaces
// Request, response and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sgi_req_if;
   logic valid;
   logic ready;
   logic signed [23:0] a_start_x;
   logic signed [23:0] a_start_y;
   logic signed [23:0] a_end_x;
   logic signed [23:0] a_end_y;
   logic signed [23:0] b_start_x;
   logic signed [23:0] b_start_y;
   logic signed [23:0] b_end_x;
   logic signed [23:0] b_end_y;
   modport source (output valid, a_start_x, a_start_y, a_end_x, a_end_y,
                   b_start_x, b_start_y, b_end_x, b_end_y, input ready);
   modport sink (input valid, a_start_x, a_start_y, a_end_x, a_end_y,
                 b_start_x, b_start_y, b_end_x, b_end_y, output ready);
endinterface

interface sgi_rsp_if;
   logic valid;
   logic ready;
   logic [1:0] status;
   logic signed [23:0] hit_x;
   logic signed [23:0] hit_y;
   modport source (output valid, status, hit_x, hit_y, input ready);
   modport sink (input valid, status, hit_x, hit_y, output ready);
endinterface

interface sgi_csr_if;
   logic valid;
   logic ready;
   logic [20:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

/* src/sgi_front.sv */
// ----------------------------------------------------------------------------
// sgi_front
// Four stages: direction vectors, cross products, cross differences, then
// sign normalization, range test and status.
// ----------------------------------------------------------------------------
module sgi_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_valid,
   input  logic signed [23:0]           a_start_x,
   input  logic signed [23:0]           a_start_y,
   input  logic signed [23:0]           a_end_x,
   input  logic signed [23:0]           a_end_y,
   input  logic signed [23:0]           b_start_x,
   input  logic signed [23:0]           b_start_y,
   input  logic signed [23:0]           b_end_x,
   input  logic signed [23:0]           b_end_y,
   input  logic [sgi_pkg::EpsW-1:0]     eps,
   output logic                         out_valid,
   output sgi_pkg::cell_type            out_data
);
   import sgi_pkg::*;

   // stage 1: differences
   logic                     v1_ff;
   logic signed [DiffW-1:0]  d0x_ff, d0y_ff, d1x_ff, d1y_ff, ex_ff, ey_ff;
   logic signed [CoordW-1:0] ax1_ff, ay1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
      end
      if (adv) begin
         d0x_ff <= DiffW'(a_end_x) - DiffW'(a_start_x);
         d0y_ff <= DiffW'(a_end_y) - DiffW'(a_start_y);
         d1x_ff <= DiffW'(b_end_x) - DiffW'(b_start_x);
         d1y_ff <= DiffW'(b_end_y) - DiffW'(b_start_y);
         ex_ff  <= DiffW'(a_start_x) - DiffW'(b_start_x);
         ey_ff  <= DiffW'(a_start_y) - DiffW'(b_start_y);
         ax1_ff <= a_start_x;
         ay1_ff <= a_start_y;
      end
   end

   // stage 2: six products, one multiplier each
   logic                     v2_ff;
   logic signed [ProdW-1:0]  pd0_ff, pd1_ff, ps0_ff, ps1_ff, pt0_ff, pt1_ff;
   logic [DiffW-1:0]         mx2_ff, my2_ff;
   logic                     nx2_ff, ny2_ff;
   logic signed [CoordW-1:0] ax2_ff, ay2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
      if (adv) begin
         pd0_ff <= ProdW'(d0x_ff) * ProdW'(d1y_ff);
         pd1_ff <= ProdW'(d1x_ff) * ProdW'(d0y_ff);
         ps0_ff <= ProdW'(d0x_ff) * ProdW'(ey_ff);
         ps1_ff <= ProdW'(d0y_ff) * ProdW'(ex_ff);
         pt0_ff <= ProdW'(d1x_ff) * ProdW'(ey_ff);
         pt1_ff <= ProdW'(d1y_ff) * ProdW'(ex_ff);
         mx2_ff <= d0x_ff[DiffW-1] ? DiffW'(-d0x_ff) : DiffW'(d0x_ff);
         my2_ff <= d0y_ff[DiffW-1] ? DiffW'(-d0y_ff) : DiffW'(d0y_ff);
         nx2_ff <= d0x_ff[DiffW-1];
         ny2_ff <= d0y_ff[DiffW-1];
         ax2_ff <= ax1_ff;
         ay2_ff <= ay1_ff;
      end
   end

   // stage 3: denominator and numerators
   logic                     v3_ff;
   logic signed [CrossW-1:0] den3_ff, sn3_ff, tn3_ff;
   logic [DiffW-1:0]         mx3_ff, my3_ff;
   logic                     nx3_ff, ny3_ff;
   logic signed [CoordW-1:0] ax3_ff, ay3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
      if (adv) begin
         den3_ff <= CrossW'(pd0_ff) - CrossW'(pd1_ff);
         sn3_ff  <= CrossW'(ps0_ff) - CrossW'(ps1_ff);
         tn3_ff  <= CrossW'(pt0_ff) - CrossW'(pt1_ff);
         mx3_ff  <= mx2_ff;
         my3_ff  <= my2_ff;
         nx3_ff  <= nx2_ff;
         ny3_ff  <= ny2_ff;
         ax3_ff  <= ax2_ff;
         ay3_ff  <= ay2_ff;
      end
   end

   // stage 4: make den positive, parallel and range tests
   logic signed [CrossW-1:0] den_n, sn_n, tn_n;
   status_type               st_in;
   logic                     v4_ff;
   cell_type                 d4_ff;
   cell_type                 d4_in;

   always_comb begin
      den_n = den3_ff;
      sn_n  = sn3_ff;
      tn_n  = tn3_ff;
      if (den3_ff < 0) begin
         den_n = -den3_ff;
         sn_n  = -sn3_ff;
         tn_n  = -tn3_ff;
      end
      if (den3_ff == 0 || den_n < CrossW'(eps)) begin
         st_in = ST_PARALLEL;
      end else if (sn_n < 0 || sn_n > den_n || tn_n < 0 || tn_n > den_n) begin
         st_in = ST_MISS;
      end else begin
         st_in = ST_HIT;
      end
      d4_in.status = st_in;
      d4_in.den    = den_n[MagW-1:0];
      d4_in.tn     = tn_n[MagW-1:0];
      d4_in.mag_x  = mx3_ff;
      d4_in.mag_y  = my3_ff;
      d4_in.neg_x  = nx3_ff;
      d4_in.neg_y  = ny3_ff;
      d4_in.ax     = ax3_ff;
      d4_in.ay     = ay3_ff;
      d4_in.lx     = '0;
      d4_in.ly     = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
      if (adv) begin
         d4_ff <= d4_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_data  = d4_ff;

endmodule

/* src/sgi_cell.sv */
// ----------------------------------------------------------------------------
// sgi_cell
// One bit of the scaled division for both coordinates; holds one beat and
// hands it to the next cell.
// ----------------------------------------------------------------------------
module sgi_cell #(
   parameter int BitIdx = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  sgi_pkg::cell_type in_data,
   output logic              out_valid,
   output sgi_pkg::cell_type out_data
);
   import sgi_pkg::*;

   logic     valid_ff;
   cell_type data_ff;
   cell_type data_in;

   // step both lanes on this cell's magnitude bit
   always_comb begin
      data_in    = in_data;
      data_in.lx = lane_step(in_data.lx, in_data.den, in_data.tn,
                             in_data.mag_x[BitIdx]);
      data_in.ly = lane_step(in_data.ly, in_data.den, in_data.tn,
                             in_data.mag_y[BitIdx]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* src/segment_intersection_2d.sv */
// Pipeline from request beat to response beat: 4 front stages,
// 25 divider cells, 1 output register.
// Throughput: one pair per cycle; the whole pipe stalls while a response
// waits, set by the single output register.
// Reset: synchronous, clears all valid flags; eps_ff returns to 66.
// ----------------------------------------------------------------------------
// segment_intersection_2d
// Pipelined 2D segment intersection test with a cell chain for the hit point.
// ----------------------------------------------------------------------------
module segment_intersection_2d (
   input  logic clock,
   input  logic reset,
   sgi_req_if.sink   req,
   sgi_rsp_if.source rsp,
   sgi_csr_if.sink   csr
);
   import sgi_pkg::*;

   logic [EpsW-1:0] eps_ff;
   logic            adv;

   // register write, always ready
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EpsReset;
      end else if (csr.valid) begin
         eps_ff <= csr.data;
      end
   end

   // global advance: move when the output slot is free or being drained
   logic rsp_valid_ff;
   assign adv       = !rsp_valid_ff || rsp.ready;
   assign req.ready = adv;

   logic     cv [NumCells+1];
   cell_type cd [NumCells+1];

   sgi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req.valid),
      .a_start_x (req.a_start_x),
      .a_start_y (req.a_start_y),
      .a_end_x   (req.a_end_x),
      .a_end_y   (req.a_end_y),
      .b_start_x (req.b_start_x),
      .b_start_y (req.b_start_y),
      .b_end_x   (req.b_end_x),
      .b_end_y   (req.b_end_y),
      .eps       (eps_ff),
      .out_valid (cv[0]),
      .out_data  (cd[0])
   );

   // divider chain, most significant magnitude bit first
   for (genvar k = 0; k < NumCells; k++) begin : g_cell
      sgi_cell #(.BitIdx(NumCells - 1 - k)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (cv[k]),
         .in_data   (cd[k]),
         .out_valid (cv[k+1]),
         .out_data  (cd[k+1])
      );
   end

   // apply signs, add start point, zero on miss or parallel
   cell_type                 last;
   logic signed [QuoW-1:0]   qx, qy;
   logic signed [CoordW-1:0] hx_in, hy_in;
   logic [1:0]               status_ff;
   logic signed [CoordW-1:0] hx_ff, hy_ff;

   always_comb begin
      last  = cd[NumCells];
      qx    = last.neg_x ? -$signed(last.lx.quo) : $signed(last.lx.quo);
      qy    = last.neg_y ? -$signed(last.ly.quo) : $signed(last.ly.quo);
      hx_in = CoordW'(QuoW'(last.ax) + qx);
      hy_in = CoordW'(QuoW'(last.ay) + qy);
      if (last.status != ST_HIT) begin
         hx_in = '0;
         hy_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= cv[NumCells];
      end
      if (adv) begin
         status_ff <= last.status;
         hx_ff     <= hx_in;
         hy_ff     <= hy_in;
      end
   end

   assign rsp.valid  = rsp_valid_ff;
   assign rsp.status = status_ff;
   assign rsp.hit_x  = hx_ff;
   assign rsp.hit_y  = hy_ff;

endmodule

/* src/sgi_checker.sv */
// ----------------------------------------------------------------------------
// sgi_checker
// Port-level checks on the segment intersection block, bound to the top.
// ----------------------------------------------------------------------------
module sgi_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [23:0] rsp_hit_x,
   input logic [23:0] rsp_hit_y
);
   import sgi_pkg::*;

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_hit_x) && $stable(rsp_hit_y))
      else $error("response changed while stalled");

   // request side is ready exactly when the output slot can move
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready out of step with response slot");

   // no hit point unless the status is a hit
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_HIT |-> rsp_hit_x == '0 && rsp_hit_y == '0)
      else $error("nonzero point on miss or parallel");

   // nothing comes out right after reset
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind segment_intersection_2d sgi_checker u_sgi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req.ready),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .rsp_status (rsp.status),
   .rsp_hit_x  (rsp.hit_x),
   .rsp_hit_y  (rsp.hit_y)
);

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for segment_intersection_2d: directed segment pairs,
// random pairs under several epsilon settings, random stalls, and a long
// response hold-off that backs up the pipeline.
// ----------------------------------------------------------------------------
module tb;
   import sgi_pkg::*;

   typedef struct {
      logic signed [23:0] ax, ay, aex, aey, bx, by, bex, bey;
   } pair_type;

   typedef struct {
      status_type         status;
      logic signed [23:0] hx;
      logic signed [23:0] hy;
   } hit_type;

   logic clock;
   logic reset;

   sgi_req_if req ();
   sgi_rsp_if rsp ();
   sgi_csr_if csr ();

   segment_intersection_2d DUT (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source),
      .csr   (csr.sink)
   );

   hit_type     hit_queue[$];
   logic [20:0] eps_model;
   int          n_err;
   int          n_beats;
   int          n_hit, n_par, n_miss;
   int          cycles;
   bit          req_idle_on;
   bit          rsp_idle_on;
   int          hold_cycles;

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > 400000) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // t*m/d truncated toward zero, 0 <= t <= d; product needs more than 64 bits
   function automatic longint scaled_quot(longint t, longint m, longint d);
      logic signed [127:0] prod;
      longint              mag;
      longint              q;
      mag  = (m < 0) ? -m : m;
      prod = 128'(t) * 128'(mag);
      q    = longint'(prod / 128'(d));
      return (m < 0) ? -q : q;
   endfunction

   function automatic hit_type predict_hit(pair_type p);
      hit_type h;
      longint  d0x, d0y, d1x, d1y, den, mag, ex, ey, sn, tn;
      h.status = ST_HIT;
      h.hx = '0;
      h.hy = '0;
      d0x = longint'(p.aex) - p.ax;
      d0y = longint'(p.aey) - p.ay;
      d1x = longint'(p.bex) - p.bx;
      d1y = longint'(p.bey) - p.by;
      den = d0x * d1y - d1x * d0y;
      mag = (den < 0) ? -den : den;
      if (den == 0 || mag < longint'(eps_model)) begin
         h.status = ST_PARALLEL;
         return h;
      end
      ex = longint'(p.ax) - p.bx;
      ey = longint'(p.ay) - p.by;
      sn = d0x * ey - d0y * ex;
      tn = d1x * ey - d1y * ex;
      if (den < 0) begin
         den = -den;
         sn = -sn;
         tn = -tn;
      end
      if (sn < 0 || sn > den || tn < 0 || tn > den) begin
         h.status = ST_MISS;
         return h;
      end
      h.hx = 24'(longint'(p.ax) + scaled_quot(tn, d0x, den));
      h.hy = 24'(longint'(p.ay) + scaled_quot(tn, d0y, den));
      return h;
   endfunction

   // response side: random stalls, long hold-off on request, checks each beat
   initial begin
      hit_type e;
      int      burst;
      rsp.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_cycles > 0) begin
            rsp.ready = 1'b0;
            hold_cycles--;
         end else if (rsp_idle_on && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(1, 16);
            rsp.ready = 1'b0;
            repeat (burst - 1) @(negedge clock);
         end else begin
            rsp.ready = 1'b1;
         end
         @(posedge clock);
         if (!reset && rsp.valid && rsp.ready) begin
            n_beats++;
            if (hit_queue.size() == 0) begin
               n_err++;
               if (n_err <= 10) $display("unexpected response beat");
            end else begin
               e = hit_queue.pop_front();
               if (rsp.status !== e.status || rsp.hit_x !== e.hx ||
                   rsp.hit_y !== e.hy) begin
                  n_err++;
                  if (n_err <= 10)
                     $display("mismatch: exp st=%0d x=%0d y=%0d got st=%0d x=%0d y=%0d",
                              e.status, e.hx, e.hy, rsp.status, rsp.hit_x,
                              rsp.hit_y);
               end
            end
         end
         @(negedge clock);
      end
   end

   // drive one pair until it is accepted, then queue its expected beat
   task automatic send_pair(pair_type p);
      hit_type h;
      int      burst;
      if (req_idle_on && $urandom_range(0, 7) == 0) begin
         burst = $urandom_range(1, 16);
         repeat (burst) @(negedge clock);
      end
      req.valid     = 1'b1;
      req.a_start_x = p.ax;
      req.a_start_y = p.ay;
      req.a_end_x   = p.aex;
      req.a_end_y   = p.aey;
      req.b_start_x = p.bx;
      req.b_start_y = p.by;
      req.b_end_x   = p.bex;
      req.b_end_y   = p.bey;
      do @(posedge clock); while (!req.ready);
      h = predict_hit(p);
      hit_queue.push_back(h);
      case (h.status)
         ST_HIT:      n_hit++;
         ST_PARALLEL: n_par++;
         default:     n_miss++;
      endcase
      @(negedge clock);
      req.valid = 1'b0;
   endtask

   task automatic drain_pipe();
      while (hit_queue.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_eps(logic [20:0] v);
      csr.valid = 1'b1;
      csr.data  = v;
      do @(posedge clock); while (!csr.ready);
      eps_model = v;
      @(negedge clock);
      csr.valid = 1'b0;
   endtask

   function automatic logic signed [23:0] rand_coord(int span);
      if (span == 0) return 24'($urandom);
      return 24'($urandom_range(0, 2 * span) - span);
   endfunction

   function automatic pair_type rand_pair();
      pair_type p;
      int       span;
      int       pick;
      pick = $urandom_range(0, 9);
      span = (pick < 2) ? 0 : (pick < 5) ? 4000 : (pick < 8) ? 200000 : 20;
      p.ax  = rand_coord(span);
      p.ay  = rand_coord(span);
      p.aex = rand_coord(span);
      p.aey = rand_coord(span);
      p.bx  = rand_coord(span);
      p.by  = rand_coord(span);
      p.bex = rand_coord(span);
      p.bey = rand_coord(span);
      // crossing shapes: B spans across A's midpoint
      if (pick == 9) begin
         p.bx  = (p.ax + p.aex) / 2 - rand_coord(3000);
         p.by  = (p.ay + p.aey) / 2 - rand_coord(3000);
         p.bex = 2 * ((p.ax + p.aex) / 2) - p.bx;
         p.bey = 2 * ((p.ay + p.aey) / 2) - p.by;
      end else if ($urandom_range(0, 15) == 0) begin
         p.bex = p.bx + (p.aex - p.ax);   // parallel
         p.bey = p.by + (p.aey - p.ay);
      end else if ($urandom_range(0, 31) == 0) begin
         p.aex = p.ax;                    // degenerate
         p.aey = p.ay;
      end
      return p;
   endfunction

   function automatic pair_type mk(int ax, int ay, int aex, int aey,
                                   int bx, int by, int bex, int bey);
      pair_type p;
      p.ax = ax; p.ay = ay; p.aex = aex; p.aey = aey;
      p.bx = bx; p.by = by; p.bex = bex; p.bey = bey;
      return p;
   endfunction

   // directed corners and special cases
   task automatic test_directed();
      int maxv, minv;
      maxv = 8388607;
      minv = -8388608;
      send_pair(mk(0, 0, 512, 512, 0, 512, 512, 0));            // X cross
      send_pair(mk(0, 0, 512, 512, 512, 0, 0, 512));            // positive den
      send_pair(mk(0, 0, 256, 0, 256, 0, 256, 256));            // endpoint touch
      send_pair(mk(0, 0, 256, 0, 0, 0, 0, 256));                // both at start
      send_pair(mk(0, 0, 256, 0, 0, 256, 256, 256));            // parallel
      send_pair(mk(5, 5, 5, 5, 0, 0, 256, 256));                // degenerate
      send_pair(mk(0, 0, 0, 0, 0, 0, 0, 0));                    // all zero
      send_pair(mk(0, 0, 256, 0, 512, -256, 512, 256));         // miss
      send_pair(mk(0, 0, 8, 0, 4, -8, 4, 8));                   // small den
      send_pair(mk(minv, minv, maxv, maxv, minv, maxv, maxv, minv));
      send_pair(mk(maxv, minv, minv, maxv, minv, minv, maxv, maxv));
      send_pair(mk(minv, 0, maxv, 0, 0, minv, 0, maxv));
      send_pair(mk(maxv, maxv, maxv, maxv, minv, minv, minv, minv));
      send_pair(mk(-1, -1, 1, 1, -1, 1, 1, -1));
      send_pair(mk(minv, minv, minv, minv, minv, minv, minv, minv));
      send_pair(mk(maxv, maxv, maxv, maxv, maxv, maxv, maxv, maxv));
      send_pair(mk(-3, 7, 1000, -999, 300, -400, 10, 20));
      send_pair(mk(0, 0, 3, 0, 1, -1, 2, 1));
      send_pair(mk(0, 0, 3, 7, 1, 5, 2, -3));
      drain_pipe();
   endtask

   task automatic test_random(int n);
      repeat (n) send_pair(rand_pair());
   endtask

   // hold the response side off while requests keep coming
   task automatic test_backpressure();
      hold_cycles = 200;
      test_random(80);
      drain_pipe();
   endtask

   initial begin
      n_err = 0; n_beats = 0; n_hit = 0; n_par = 0; n_miss = 0;
      hold_cycles = 0;
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      eps_model   = EpsReset;
      req.valid = 1'b0;
      req.a_start_x = '0; req.a_start_y = '0; req.a_end_x = '0; req.a_end_y = '0;
      req.b_start_x = '0; req.b_start_y = '0; req.b_end_x = '0; req.b_end_y = '0;
      csr.valid = 1'b0;
      csr.data  = '0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      write_eps(21'd0);
      test_directed();
      write_eps(21'h1FFFFF);
      test_directed();
      write_eps(21'd1048576);
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      test_random(300);
      drain_pipe();
      write_eps(21'd1);
      test_random(300);
      drain_pipe();
      test_backpressure();
      write_eps(21'd66);
      test_random(300);
      drain_pipe();
      write_eps(21'($urandom_range(0, 5000)));
      test_random(250);
      drain_pipe();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      write_eps(21'd0);
      test_random(260);
      drain_pipe();

      $display("%0d pairs checked: %0d hits, %0d parallel, %0d misses",
               n_beats, n_hit, n_par, n_miss);
      $display("epsilon swept 0..max, stalls and long hold-off applied, %0d errors",
               n_err);
      if (n_err == 0 && hit_queue.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
